### rtl/fhr_pkg.sv
// Shared types, constants and helpers for the handle-addressed linked queue.
// No dependencies; used by every module under rtl.
`default_nettype none
package fhr_pkg;
    localparam int POOL_DEPTH   = 64;
    localparam int PAYLOAD_BITS = 16;
    localparam int TIME_W       = 16;
    localparam int SLOT_W       = $clog2(POOL_DEPTH);
    localparam int LINK_W       = SLOT_W + 1;

    localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {SLOT_W{1'b0}}};

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_PEEK   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic [PAYLOAD_BITS-1:0] entry_payload;
        logic [TIME_W-1:0]       entry_time;
        logic [SLOT_W-1:0]       entry_handle;
    } in_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0]       result_handle;
        logic [PAYLOAD_BITS-1:0] result_payload;
        logic [TIME_W-1:0]       result_time;
        logic [1:0]              status;
    } out_word_t;

    typedef struct packed {
        logic     valid;
        in_word_t word;
    } q_link_t;

    function automatic logic [SLOT_W-1:0] first_free(input logic [POOL_DEPTH-1:0] live);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--)
        begin
            if (!live[i])
            begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/fhr_front.sv
// Front end: accepts words into a two-entry queue ahead of the executor.
// Depends on fhr_pkg.
`default_nettype none
module fhr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire fhr_pkg::in_word_t in_word,
    output fhr_pkg::q_link_t       q_out,
    input  wire logic              q_take
);
    fhr_pkg::in_word_t mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push, pop;

    assign in_stall = (count_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign pop  = q_take && (count_reg != 2'd0);
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_word;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !push || pop)
        else $error("queue overflow");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd0 && !pop |=> count_reg != 2'd0)
        else $error("queue lost a word");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

### rtl/fhr_exec.sv
// Back end: runs push, pop, delete and peek on the linked pool memories.
// Depends on fhr_pkg.
`default_nettype none
module fhr_exec (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fhr_pkg::q_link_t  q_in,
    output logic                   q_take,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output fhr_pkg::out_word_t     out_word
);
    localparam int SW = fhr_pkg::SLOT_W;
    localparam int LW = fhr_pkg::LINK_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [fhr_pkg::PAYLOAD_BITS-1:0] pay_mem [fhr_pkg::POOL_DEPTH];
    logic [fhr_pkg::TIME_W-1:0]       time_mem [fhr_pkg::POOL_DEPTH];
    logic [LW-1:0]                    next_mem [fhr_pkg::POOL_DEPTH];
    logic [LW-1:0]                    prev_mem [fhr_pkg::POOL_DEPTH];

    logic [fhr_pkg::PAYLOAD_BITS-1:0] pay_rd_reg;
    logic [fhr_pkg::TIME_W-1:0]       time_rd_reg;
    logic [LW-1:0]                    next_rd_reg, prev_rd_reg;

    logic [fhr_pkg::POOL_DEPTH-1:0] live_reg, live_next;
    logic [LW-1:0]                  head_reg, head_next;
    logic [LW-1:0]                  tail_reg, tail_next;

    logic [1:0]                       op_reg;
    logic [1:0]                       st_reg;
    logic [SW-1:0]                    slot_reg;
    logic [fhr_pkg::PAYLOAD_BITS-1:0] wpay_reg;
    logic [fhr_pkg::TIME_W-1:0]       wtime_reg;

    logic               out_valid_reg, out_valid_next;
    fhr_pkg::out_word_t out_reg, out_next;

    logic [1:0]    st_dec;
    logic [SW-1:0] slot_dec;
    logic          ok, is_push, is_unlink;
    logic          nx_we, pv_we, dt_we;
    logic [SW-1:0] nx_addr, pv_addr;
    logic [LW-1:0] nx_data, pv_data;

    assign q_take    = (state_reg == S_IDLE) && q_in.valid && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    assign ok        = (st_reg == fhr_pkg::ST_OK);
    assign is_push   = (op_reg == fhr_pkg::OP_PUSH);
    assign is_unlink = (op_reg == fhr_pkg::OP_POP) || (op_reg == fhr_pkg::OP_DELETE);

    always_comb
    begin
        st_dec   = fhr_pkg::ST_OK;
        slot_dec = head_reg[SW-1:0];
        case (q_in.word.op)
            fhr_pkg::OP_PUSH:
            begin
                slot_dec = fhr_pkg::first_free(live_reg);
                if (&live_reg)
                begin
                    st_dec = fhr_pkg::ST_FULL;
                end
            end
            fhr_pkg::OP_DELETE:
            begin
                slot_dec = q_in.word.entry_handle;
                if (!live_reg[q_in.word.entry_handle])
                begin
                    st_dec = fhr_pkg::ST_BAD;
                end
            end
            default:
            begin
                if (head_reg[SW])
                begin
                    st_dec = fhr_pkg::ST_EMPTY;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        live_next      = live_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        dt_we   = 1'b0;
        nx_we   = 1'b0;
        pv_we   = 1'b0;
        nx_addr = slot_reg;
        pv_addr = slot_reg;
        nx_data = fhr_pkg::LINK_NULL;
        pv_data = tail_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_take)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_UPD;
                if (is_push && ok)
                begin
                    dt_we = 1'b1;
                    nx_we = 1'b1;
                    pv_we = 1'b1;
                end
            end
            S_UPD:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                out_next       = '0;
                out_next.status = st_reg;
                if (ok)
                begin
                    if (is_push)
                    begin
                        out_next.result_handle = slot_reg;
                        live_next[slot_reg] = 1'b1;
                        tail_next = {1'b0, slot_reg};
                        if (tail_reg[SW])
                        begin
                            head_next = {1'b0, slot_reg};
                        end
                        else
                        begin
                            nx_we   = 1'b1;
                            nx_addr = tail_reg[SW-1:0];
                            nx_data = {1'b0, slot_reg};
                        end
                    end
                    else if (is_unlink)
                    begin
                        if (op_reg == fhr_pkg::OP_POP)
                        begin
                            out_next.result_payload = pay_rd_reg;
                            out_next.result_time    = time_rd_reg;
                        end
                        live_next[slot_reg] = 1'b0;
                        if (prev_rd_reg[SW])
                        begin
                            head_next = next_rd_reg;
                        end
                        else
                        begin
                            nx_we   = 1'b1;
                            nx_addr = prev_rd_reg[SW-1:0];
                            nx_data = next_rd_reg;
                        end
                        if (next_rd_reg[SW])
                        begin
                            tail_next = prev_rd_reg;
                        end
                        else
                        begin
                            pv_we   = 1'b1;
                            pv_addr = next_rd_reg[SW-1:0];
                            pv_data = prev_rd_reg;
                        end
                    end
                    else
                    begin
                        out_next.result_time = time_rd_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_reg      <= '0;
            head_reg      <= fhr_pkg::LINK_NULL;
            tail_reg      <= fhr_pkg::LINK_NULL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (q_take)
        begin
            op_reg    <= q_in.word.op;
            st_reg    <= st_dec;
            slot_reg  <= slot_dec;
            wpay_reg  <= q_in.word.entry_payload;
            wtime_reg <= q_in.word.entry_time;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dt_we)
        begin
            pay_mem[slot_reg]  <= wpay_reg;
            time_mem[slot_reg] <= wtime_reg;
        end
        pay_rd_reg  <= pay_mem[slot_reg];
        time_rd_reg <= time_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_addr] <= nx_data;
        end
        next_rd_reg <= next_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
        begin
            prev_mem[pv_addr] <= pv_data;
        end
        prev_rd_reg <= prev_mem[slot_reg];
    end

`ifndef SYNTHESIS
    a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg[SW] == tail_reg[SW])
        else $error("head and tail disagree on empty");
    a_empty_pool: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg == '0 |-> head_reg[SW])
        else $error("head set with no live entries");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |-> !out_valid_reg || !out_stall)
        else $error("result would overwrite a pending word");
    a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
        !head_reg[SW] |-> live_reg[head_reg[SW-1:0]])
        else $error("head points at a free slot");
`endif
endmodule
`default_nettype wire

### rtl/fifo_with_handle_removal_core.sv
// Handle-addressed linked queue: front queue plus linked-pool executor.
// Each word taken passes through the read state and the update state; the result word is registered.
// A new word is taken only when the executor is idle and the result register has drained,
// so the read-then-rewrite link sequence of one word finishes before the next word starts.
// Reset: asynchronous, active low; empties the queue, frees every slot.
// Depends on fhr_pkg, fhr_front, fhr_exec.
`default_nettype none
module fifo_with_handle_removal_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire fhr_pkg::in_word_t  in_word,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output fhr_pkg::out_word_t      out_word
);
    fhr_pkg::q_link_t q_link;
    logic             q_take;

    fhr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .q_out    (q_link),
        .q_take   (q_take)
    );

    fhr_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_in      (q_link),
        .q_take    (q_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );
endmodule
`default_nettype wire
